[design/pfc_pkg.sv]
// Shared widths, constants, types and helpers of the PID feedforward controller.
`timescale 1ns / 1ps
package pfc_pkg;

   localparam int unsigned DataW  = 32;
   localparam int unsigned LimW   = 31;
   localparam int unsigned VelW   = 48;
   localparam int unsigned MulAW  = 49;
   localparam int unsigned MulBW  = 33;
   localparam int unsigned ProdW  = MulAW + MulBW;
   localparam int unsigned TermW  = ProdW - 16;
   localparam int unsigned SumW   = 64;
   localparam int unsigned CntW   = $clog2(MulBW + 1);

   localparam logic [DataW-1:0] SamplePeriodQ32 = 32'd429497;

   localparam logic signed [TermW-1:0] S48Max = (66'sd1 <<< 47) - 66'sd1;
   localparam logic signed [TermW-1:0] S48Min = -(66'sd1 <<< 47);

   // request command codes
   typedef enum logic [1:0] {CmdSample, CmdEnable, CmdDisable, CmdNop} cmd_type;

   // configuration register indexes
   typedef enum logic [2:0] {RegGainP, RegGainI, RegGainD, RegGainJerk, RegGainVel,
                             RegGainAcc, RegOutLimit, RegIntLimit} reg_type;

   typedef struct packed {
      logic load;
      logic step;
      logic last;
   } mul_ctrl_type;

   function automatic logic signed [VelW-1:0] sat48(input logic signed [TermW-1:0] x);
      logic signed [VelW-1:0] r;
      if (x > S48Max) begin
         r = S48Max[VelW-1:0];
      end else if (x < S48Min) begin
         r = S48Min[VelW-1:0];
      end else begin
         r = x[VelW-1:0];
      end
      return r;
   endfunction

endpackage

[design/pfc_serial_mul.sv]
// Radix-2 shift-add signed multiplier, one multiplier bit per cycle while ctrl.step is high.
`timescale 1ns / 1ps
module pfc_serial_mul (
   input  logic                                 clock,
   input  pfc_pkg::mul_ctrl_type                ctrl,
   input  logic signed [pfc_pkg::MulAW-1:0]     a,
   input  logic signed [pfc_pkg::MulBW-1:0]     b,
   output logic signed [pfc_pkg::ProdW-1:0]     prod
);

   logic [pfc_pkg::ProdW-1:0] prod_ff, prod_in;
   logic signed [pfc_pkg::MulAW:0] upper, addend, partial;

   always_comb begin
      upper   = {prod_ff[pfc_pkg::ProdW-1], prod_ff[pfc_pkg::ProdW-1:pfc_pkg::MulBW]};
      // last bit of a two's complement multiplier carries negative weight
      addend  = ctrl.last ? -{a[pfc_pkg::MulAW-1], a} : {a[pfc_pkg::MulAW-1], a};
      partial = upper + (prod_ff[0] ? addend : '0);
      prod_in = prod_ff;
      if (ctrl.load) begin
         prod_in = {{pfc_pkg::MulAW{1'b0}}, b};
      end else if (ctrl.step) begin
         prod_in = {partial, prod_ff[pfc_pkg::MulBW-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

[design/pid_feedforward_controller_core.sv]
// Top level of the PID position controller with velocity, acceleration and jerk feedforward.
`timescale 1ns / 1ps
// Sequence: a sample beat runs 9 products in StMul, then StDone registers rsp_valid;
//   enable/disable/no-op beats go from StIdle straight to StDone after the req accept.
// Flow: one item at a time, through the shared bit-serial multiplier; a held result
//   stalls the next item in StDone but does not hold off its req.
// Reset: synchronous, active high; clears all history, the integral, the enable flag and
//   the gains, and sets output_limit to full scale. No clearing pass is needed.
module pid_feedforward_controller_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic signed [31:0] req_setpoint,
   input  logic signed [31:0] req_measured,
   input  logic        req_fault,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [31:0] rsp_drive,
   output logic        rsp_running,
   output logic signed [31:0] rsp_control_error,
   output logic        rsp_refused,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   typedef enum logic [1:0] {StIdle, StMul, StDone} state_type;
   typedef enum logic [3:0] {OpVel, OpAcc, OpJerk, OpInt, OpProp, OpDer,
                             OpJff, OpVff, OpAff} op_type;

   // configuration
   logic signed [31:0] gain_p_ff, gain_i_ff, gain_d_ff, gain_jerk_ff, gain_vel_ff, gain_acc_ff;
   logic [30:0] out_limit_ff, int_limit_ff;

   // controller history
   logic signed [31:0] prev_sp_ff, prev_sp_in, prev_ms_ff, prev_ms_in;
   logic signed [47:0] prev_vel_ff, prev_vel_in, prev_acc_ff, prev_acc_in;
   logic signed [31:0] integ_acc_ff, integ_acc_in, last_err_ff, last_err_in;
   logic enabled_ff, enabled_in;

   // per-item working registers
   state_type state_ff, state_in;
   op_type op_ff, op_in, op_next;
   logic [pfc_pkg::CntW-1:0] cnt_ff, cnt_in;
   pfc_pkg::cmd_type cmd_ff, cmd_in;
   logic fault_ff, fault_in;
   logic signed [31:0] sp_ff, sp_in, ms_ff, ms_in, err_ff, err_in, integ_ff, integ_in;
   logic signed [32:0] diff_ff, diff_in, dmeas_ff, dmeas_in;
   logic signed [47:0] vel_ff, vel_in, acc_ff, acc_in, jerk_ff, jerk_in;
   logic signed [pfc_pkg::SumW-1:0] sum_ff, sum_in;

   // result register
   logic rsp_valid_ff, rsp_valid_in, running_ff, running_in, refused_ff, refused_in;
   logic signed [31:0] drive_ff, drive_in, cerr_ff, cerr_in;

   pfc_pkg::mul_ctrl_type mul_ctrl;
   logic signed [pfc_pkg::MulAW-1:0] mul_a;
   logic signed [pfc_pkg::MulBW-1:0] mul_b;
   logic signed [pfc_pkg::ProdW-1:0] mul_prod;

   logic signed [pfc_pkg::TermW-1:0] term;
   logic signed [32:0] err_wide;
   logic signed [pfc_pkg::SumW-1:0] isum, ilim, olim;
   logic rsp_free;

   pfc_serial_mul u_mul (
      .clock (clock),
      .ctrl  (mul_ctrl),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (mul_prod)
   );

   assign req_ready = (state_ff == StIdle);
   assign csr_ready = 1'b1;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // multiplicand follows the operation in flight
   always_comb begin
      unique case (op_ff)
         OpVel:          mul_a = 49'(diff_ff);
         OpAcc:          mul_a = 49'(vel_ff) - 49'(prev_vel_ff);
         OpJerk:         mul_a = 49'(acc_ff) - 49'(prev_acc_ff);
         OpInt, OpProp:  mul_a = 49'(err_ff);
         OpDer:          mul_a = 49'(dmeas_ff);
         OpJff:          mul_a = 49'(jerk_ff);
         OpVff:          mul_a = 49'(vel_ff);
         OpAff:          mul_a = 49'(acc_ff);
         default:        mul_a = '0;
      endcase
   end

   // scaled product: Q16.16 terms drop 16 bits, Q16.32 terms drop 32
   always_comb begin
      if (op_ff == OpVel || op_ff == OpInt || op_ff == OpProp || op_ff == OpDer) begin
         term = mul_prod[pfc_pkg::ProdW-1:16];
      end else begin
         term = {{16{mul_prod[pfc_pkg::ProdW-1]}}, mul_prod[pfc_pkg::ProdW-1:32]};
      end
   end

   always_comb begin
      op_next = op_type'(op_ff + 4'd1);
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      cnt_in       = cnt_ff;
      cmd_in       = cmd_ff;
      fault_in     = fault_ff;
      sp_in        = sp_ff;
      ms_in        = ms_ff;
      err_in       = err_ff;
      diff_in      = diff_ff;
      dmeas_in     = dmeas_ff;
      vel_in       = vel_ff;
      acc_in       = acc_ff;
      jerk_in      = jerk_ff;
      integ_in     = integ_ff;
      sum_in       = sum_ff;
      prev_sp_in   = prev_sp_ff;
      prev_ms_in   = prev_ms_ff;
      prev_vel_in  = prev_vel_ff;
      prev_acc_in  = prev_acc_ff;
      integ_acc_in = integ_acc_ff;
      last_err_in  = last_err_ff;
      enabled_in   = enabled_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      drive_in     = drive_ff;
      running_in   = running_ff;
      cerr_in      = cerr_ff;
      refused_in   = refused_ff;
      mul_ctrl     = '0;
      mul_b        = '0;
      err_wide     = 33'(req_setpoint) - 33'(req_measured);
      isum         = 64'(integ_acc_ff) + term[pfc_pkg::SumW-1:0];
      ilim         = {33'd0, int_limit_ff};
      olim         = {33'd0, out_limit_ff};

      unique case (state_ff)
         StIdle: begin
            if (req_valid) begin
               cmd_in   = pfc_pkg::cmd_type'(req_cmd);
               fault_in = req_fault;
               sp_in    = req_setpoint;
               ms_in    = req_measured;
               diff_in  = 33'(req_setpoint) - 33'(prev_sp_ff);
               dmeas_in = 33'(req_measured) - 33'(prev_ms_ff);
               if (err_wide > 33'sd2147483647) begin
                  err_in = 32'sh7fffffff;
               end else if (err_wide < -33'sd2147483648) begin
                  err_in = 32'sh80000000;
               end else begin
                  err_in = err_wide[31:0];
               end
               if (pfc_pkg::cmd_type'(req_cmd) == pfc_pkg::CmdSample) begin
                  state_in      = StMul;
                  op_in         = OpVel;
                  cnt_in        = '0;
                  mul_ctrl.load = 1'b1;
                  mul_b         = {1'b0, pfc_pkg::SamplePeriodQ32};
               end else begin
                  state_in = StDone;
               end
            end
         end
         StMul: begin
            if (cnt_ff != pfc_pkg::CntW'(pfc_pkg::MulBW)) begin
               // advance one multiplier bit
               mul_ctrl.step = 1'b1;
               mul_ctrl.last = (cnt_ff == pfc_pkg::CntW'(pfc_pkg::MulBW - 1));
               cnt_in        = cnt_ff + 1'b1;
            end else begin
               unique case (op_ff)
                  OpVel:  vel_in  = pfc_pkg::sat48(term);
                  OpAcc:  acc_in  = pfc_pkg::sat48(term);
                  OpJerk: jerk_in = pfc_pkg::sat48(term);
                  OpInt: begin
                     // clamp the new integral to the limit
                     if (isum > ilim) begin
                        integ_in = ilim[31:0];
                     end else if (isum < -ilim) begin
                        integ_in = 32'(-ilim);
                     end else begin
                        integ_in = isum[31:0];
                     end
                     sum_in = 64'(integ_in);
                  end
                  default: sum_in = sum_ff + term[pfc_pkg::SumW-1:0];
               endcase
               if (op_ff == OpAff) begin
                  state_in = StDone;
               end else begin
                  op_in         = op_next;
                  cnt_in        = '0;
                  mul_ctrl.load = 1'b1;
                  unique case (op_next)
                     OpVel, OpAcc, OpJerk: mul_b = {1'b0, pfc_pkg::SamplePeriodQ32};
                     OpInt:   mul_b = 33'(gain_i_ff);
                     OpProp:  mul_b = 33'(gain_p_ff);
                     OpDer:   mul_b = 33'(gain_d_ff);
                     OpJff:   mul_b = 33'(gain_jerk_ff);
                     OpVff:   mul_b = 33'(gain_vel_ff);
                     OpAff:   mul_b = 33'(gain_acc_ff);
                     default: mul_b = '0;
                  endcase
               end
            end
         end
         StDone: begin
            if (rsp_free) begin
               drive_in   = '0;
               refused_in = 1'b0;
               unique case (cmd_ff)
                  pfc_pkg::CmdSample: begin
                     integ_acc_in = integ_ff;
                     last_err_in  = err_ff;
                     prev_sp_in   = sp_ff;
                     prev_ms_in   = ms_ff;
                     prev_vel_in  = vel_ff;
                     prev_acc_in  = acc_ff;
                     if (enabled_ff) begin
                        if (sum_ff > olim) begin
                           drive_in = olim[31:0];
                        end else if (sum_ff < -olim) begin
                           drive_in = 32'(-olim);
                        end else begin
                           drive_in = sum_ff[31:0];
                        end
                     end
                  end
                  pfc_pkg::CmdEnable: begin
                     if (fault_ff) begin
                        refused_in = 1'b1;
                     end else begin
                        enabled_in   = 1'b1;
                        integ_acc_in = '0;
                     end
                  end
                  pfc_pkg::CmdDisable: begin
                     if (enabled_ff) begin
                        enabled_in   = 1'b0;
                        integ_acc_in = '0;
                     end
                  end
                  pfc_pkg::CmdNop: begin
                  end
               endcase
               running_in   = (cmd_ff == pfc_pkg::CmdEnable && !fault_ff) ? 1'b1 :
                              (cmd_ff == pfc_pkg::CmdDisable) ? 1'b0 : enabled_ff;
               cerr_in      = (cmd_ff == pfc_pkg::CmdSample) ? err_ff : last_err_ff;
               rsp_valid_in = 1'b1;
               state_in     = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         op_ff        <= OpVel;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         enabled_ff   <= 1'b0;
         prev_sp_ff   <= '0;
         prev_ms_ff   <= '0;
         prev_vel_ff  <= '0;
         prev_acc_ff  <= '0;
         integ_acc_ff <= '0;
         last_err_ff  <= '0;
         gain_p_ff    <= '0;
         gain_i_ff    <= '0;
         gain_d_ff    <= '0;
         gain_jerk_ff <= '0;
         gain_vel_ff  <= '0;
         gain_acc_ff  <= '0;
         out_limit_ff <= 31'h7fffffff;
         int_limit_ff <= '0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         enabled_ff   <= enabled_in;
         prev_sp_ff   <= prev_sp_in;
         prev_ms_ff   <= prev_ms_in;
         prev_vel_ff  <= prev_vel_in;
         prev_acc_ff  <= prev_acc_in;
         integ_acc_ff <= integ_acc_in;
         last_err_ff  <= last_err_in;
         if (csr_valid) begin
            unique case (pfc_pkg::reg_type'(csr_index))
               pfc_pkg::RegGainP:    gain_p_ff    <= csr_data;
               pfc_pkg::RegGainI:    gain_i_ff    <= csr_data;
               pfc_pkg::RegGainD:    gain_d_ff    <= csr_data;
               pfc_pkg::RegGainJerk: gain_jerk_ff <= csr_data;
               pfc_pkg::RegGainVel:  gain_vel_ff  <= csr_data;
               pfc_pkg::RegGainAcc:  gain_acc_ff  <= csr_data;
               pfc_pkg::RegOutLimit: out_limit_ff <= csr_data[30:0];
               pfc_pkg::RegIntLimit: int_limit_ff <= csr_data[30:0];
            endcase
         end
      end
      cmd_ff     <= cmd_in;
      fault_ff   <= fault_in;
      sp_ff      <= sp_in;
      ms_ff      <= ms_in;
      err_ff     <= err_in;
      diff_ff    <= diff_in;
      dmeas_ff   <= dmeas_in;
      vel_ff     <= vel_in;
      acc_ff     <= acc_in;
      jerk_ff    <= jerk_in;
      integ_ff   <= integ_in;
      sum_ff     <= sum_in;
      drive_ff   <= drive_in;
      running_ff <= running_in;
      cerr_ff    <= cerr_in;
      refused_ff <= refused_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_drive         = drive_ff;
   assign rsp_running       = running_ff;
   assign rsp_control_error = cerr_ff;
   assign rsp_refused       = refused_ff;

endmodule
